/* hdl/bsc_pkg.sv */
package bsc_pkg;

  localparam int NumCal = 8;
  localparam int CalW = 16;
  localparam int CfgIdxW = $clog2(NumCal);

  localparam logic [CalW-1:0] CrcPoly = 16'h3000;
  localparam logic [CalW-1:0] Word7Mask = 16'hff00;

  typedef logic [NumCal-1:0][CalW-1:0] cal_bank_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FACTORY,
    REG_SENS,
    REG_OFFSET,
    REG_SENS_TC,
    REG_OFFSET_TC,
    REG_TREF,
    REG_TEMPSENS,
    REG_CRC
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_COEF = 3'd1,
    ST_CRC_BAD   = 3'd2,
    ST_D1_ZERO   = 3'd3,
    ST_D2_ZERO   = 3'd4
  } status_t;

  typedef struct packed {
    logic zero_coef;
    logic d1_zero;
    logic d2_zero;
  } fault_t;

  // one calibration word through the crc, high byte first
  function automatic logic [CalW-1:0] crc_word(input logic [CalW-1:0] rem_in,
                                               input logic [CalW-1:0] word);
    logic [CalW-1:0] r;
    r = rem_in;
    for (int b = 0; b < 2; b++) begin
      r = r ^ {8'd0, word[CalW-1-8*b -: 8]};
      for (int i = 0; i < 8; i++) begin
        r = r[CalW-1] ? ({r[CalW-2:0], 1'b0} ^ CrcPoly) : {r[CalW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

/* hdl/bsc_crc4.sv */
module bsc_crc4 import bsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cal_bank_t cal,
  output logic [3:0] crc
);

  localparam int NumRem = NumCal - 1;

  // crc chain over the calibration bank, one word per register
  // (the first register takes two words)
  logic [NumRem-1:0][CalW-1:0] rem;
  cal_bank_t cal_m;

  always_comb begin
    cal_m = cal;
    cal_m[REG_CRC] = cal[REG_CRC] & Word7Mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // crc of an all-zero bank is zero
      rem <= '0;
    end else begin
      rem[0] <= crc_word(crc_word('0, cal_m[0]), cal_m[1]);
      for (int k = 1; k < NumRem; k++) begin
        rem[k] <= crc_word(rem[k-1], cal_m[k+1]);
      end
    end
  end

  assign crc = rem[NumRem-1][CalW-1 -: 4];

endmodule

/* hdl/baro_sensor_compensation.sv */
// channel  direction  handshake             payload
// cfg      in         cfg_write             cfg_index, cfg_data
// in       in         in_valid / in_ready   raw_pressure, raw_temperature
// out      out        out_valid / out_ready status, pressure, temperature_centi,
//                                           crc_stored, crc_computed
//
// nine register stages, one conversion pair per cycle unless the output stalls on
// out_ready; the wide multiply d1 * sens is split in two partial products (stages 6 and 7)
// reset clears the calibration bank and all stage valid bits
// each stage loads when it is empty or the stage after it moves, so a stalled
// output holds its result and bubbles upstream still close up
// the crc check settles once a calibration write has passed through the crc chain registers
module baro_sensor_compensation import bsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CalW-1:0]          cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [23:0]              raw_pressure,
  input  logic [23:0]              raw_temperature,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               status,
  output logic signed [31:0]       pressure,
  output logic signed [18:0]       temperature_centi,
  output logic [3:0]               crc_stored,
  output logic [3:0]               crc_computed
);

  localparam int NumStages = 9;
  localparam int RawW = 24;
  localparam int DtW = 25;
  localparam int ProdW = 42;
  localparam int DtSqW = 49;
  localparam int T3xW = DtSqW + 2;
  localparam int T2W = 17;
  localparam int TempW = 19;
  localparam int DltW = 18;
  localparam int Dl2W = 19;
  localparam int SqW = 35;
  localparam int OffW = 38;
  localparam int SplitW = 19;
  localparam int PpLoW = RawW + SplitW;
  localparam int PpHiW = RawW + 1 + OffW - SplitW;
  localparam int FullW = 62;
  localparam int DiffW = 41;
  localparam int PresW = 32;

  localparam int ShTemp = 23;
  localparam int ShOff = 5;
  localparam int ShSens = 7;
  localparam int ShT2 = 33;
  localparam int ShP1 = 21;
  localparam int ShP2 = 15;
  localparam int OffShift = 18;
  localparam int SensShift = 17;
  localparam int TRefCenti = 2000;
  localparam int TLowCenti = -1500;

  localparam logic signed [ProdW-1:0] BiasTemp =
    $signed({{(ProdW-ShTemp){1'b0}}, {ShTemp{1'b1}}});
  localparam logic signed [ProdW-1:0] BiasOff =
    $signed({{(ProdW-ShOff){1'b0}}, {ShOff{1'b1}}});
  localparam logic signed [ProdW-1:0] BiasSens =
    $signed({{(ProdW-ShSens){1'b0}}, {ShSens{1'b1}}});
  localparam logic signed [FullW-1:0] BiasP1 =
    $signed({{(FullW-ShP1){1'b0}}, {ShP1{1'b1}}});
  localparam logic signed [DiffW-1:0] BiasP2 =
    $signed({{(DiffW-ShP2){1'b0}}, {ShP2{1'b1}}});

  // calibration bank
  cal_bank_t cal;
  logic [3:0] crc_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_write) begin
      cal[cfg_index] <= cfg_data;
    end
  end

  bsc_crc4 u_crc (
    .clk (clk),
    .rst (rst),
    .cal (cal),
    .crc (crc_result)
  );

  assign crc_stored = cal[REG_CRC][3:0];
  assign crc_computed = crc_result;

  // stage control
  logic [NumStages:1]   vld;
  logic [NumStages+1:1] adv;

  always_comb begin
    adv[NumStages+1] = out_ready;
    for (int k = NumStages; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= in_valid;
      for (int k = 2; k <= NumStages; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign in_ready = adv[1];
  assign out_valid = vld[NumStages];

  // stage 1: dt and input faults
  logic [RawW-1:0]        s1_d1;
  logic signed [DtW-1:0]  s1_dt, s1_dt_next;
  fault_t                 s1_flags, s1_flags_next;

  always_comb begin
    s1_flags_next.zero_coef = (cal[REG_SENS] == '0) || (cal[REG_OFFSET] == '0) ||
                              (cal[REG_SENS_TC] == '0) || (cal[REG_OFFSET_TC] == '0) ||
                              (cal[REG_TREF] == '0) || (cal[REG_TEMPSENS] == '0);
    s1_flags_next.d1_zero = (raw_pressure == '0);
    s1_flags_next.d2_zero = (raw_temperature == '0);
    s1_dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal[REG_TREF], 8'd0});
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_d1 <= raw_pressure;
      s1_dt <= s1_dt_next;
      s1_flags <= s1_flags_next;
    end
  end

  // stage 2: products with dt
  logic [RawW-1:0]            s2_d1;
  fault_t                     s2_flags;
  logic signed [ProdW-1:0]    s2_dtc6, s2_dtc6_next;
  logic signed [ProdW-1:0]    s2_c4dt, s2_c4dt_next;
  logic signed [ProdW-1:0]    s2_c3dt, s2_c3dt_next;
  logic [DtSqW-1:0]           s2_dtsq, s2_dtsq_next;
  logic signed [2*DtW-1:0]    dt_sq;

  always_comb begin
    s2_dtc6_next = s1_dt * $signed({1'b0, cal[REG_TEMPSENS]});
    s2_c4dt_next = s1_dt * $signed({1'b0, cal[REG_OFFSET_TC]});
    s2_c3dt_next = s1_dt * $signed({1'b0, cal[REG_SENS_TC]});
    dt_sq = s1_dt * s1_dt;
    s2_dtsq_next = dt_sq[DtSqW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_d1 <= s1_d1;
      s2_flags <= s1_flags;
      s2_dtc6 <= s2_dtc6_next;
      s2_c4dt <= s2_c4dt_next;
      s2_c3dt <= s2_c3dt_next;
      s2_dtsq <= s2_dtsq_next;
    end
  end

  // stage 3: first-order temperature, offset and sensitivity
  logic [RawW-1:0]          s3_d1;
  fault_t                   s3_flags;
  logic signed [TempW-1:0]  s3_temp, s3_temp_next;
  logic signed [DltW-1:0]   s3_dlt, s3_dlt_next;
  logic signed [Dl2W-1:0]   s3_dl2, s3_dl2_next;
  logic                     s3_cold, s3_cold_next;
  logic                     s3_vcold, s3_vcold_next;
  logic signed [OffW-1:0]   s3_off, s3_off_next;
  logic signed [OffW-1:0]   s3_sens, s3_sens_next;
  logic [T2W-1:0]           s3_t2, s3_t2_next;
  logic signed [ProdW-1:0]  t_bias, t_quot;
  logic signed [ProdW-1:0]  off_bias, off_quot;
  logic signed [ProdW-1:0]  sens_bias, sens_quot;
  logic [T3xW-1:0]          t3x;

  always_comb begin
    // signed divides by powers of two round toward zero
    t_bias = s2_dtc6 + (s2_dtc6[ProdW-1] ? BiasTemp : '0);
    t_quot = t_bias >>> ShTemp;
    s3_dlt_next = t_quot[DltW-1:0];
    s3_temp_next = TempW'(s3_dlt_next) + TempW'(TRefCenti);
    s3_dl2_next = Dl2W'(s3_dlt_next) + Dl2W'(TRefCenti - TLowCenti);
    s3_cold_next = s3_dlt_next[DltW-1];
    s3_vcold_next = s3_dl2_next[Dl2W-1];

    off_bias = s2_c4dt + (s2_c4dt[ProdW-1] ? BiasOff : '0);
    off_quot = off_bias >>> ShOff;
    s3_off_next = $signed({{(OffW-CalW-OffShift){1'b0}}, cal[REG_OFFSET], {OffShift{1'b0}}})
                  + OffW'(off_quot);

    sens_bias = s2_c3dt + (s2_c3dt[ProdW-1] ? BiasSens : '0);
    sens_quot = sens_bias >>> ShSens;
    s3_sens_next = $signed({{(OffW-CalW-SensShift){1'b0}}, cal[REG_SENS], {SensShift{1'b0}}})
                   + OffW'(sens_quot);

    t3x = {1'b0, s2_dtsq, 1'b0} + {2'b0, s2_dtsq};
    s3_t2_next = t3x[ShT2 +: T2W];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_d1 <= s2_d1;
      s3_flags <= s2_flags;
      s3_temp <= s3_temp_next;
      s3_dlt <= s3_dlt_next;
      s3_dl2 <= s3_dl2_next;
      s3_cold <= s3_cold_next;
      s3_vcold <= s3_vcold_next;
      s3_off <= s3_off_next;
      s3_sens <= s3_sens_next;
      s3_t2 <= s3_t2_next;
    end
  end

  // stage 4: squares for the cold correction, final temperature
  logic [RawW-1:0]          s4_d1;
  fault_t                   s4_flags;
  logic signed [TempW-1:0]  s4_temp, s4_temp_next;
  logic                     s4_cold, s4_vcold;
  logic [SqW-1:0]           s4_dltsq, s4_dltsq_next;
  logic [SqW-1:0]           s4_dl2sq, s4_dl2sq_next;
  logic signed [OffW-1:0]   s4_off, s4_sens;
  logic signed [2*DltW-1:0] dlt_sq;
  logic signed [2*Dl2W-1:0] dl2_sq;

  always_comb begin
    dlt_sq = s3_dlt * s3_dlt;
    dl2_sq = s3_dl2 * s3_dl2;
    s4_dltsq_next = dlt_sq[SqW-1:0];
    s4_dl2sq_next = dl2_sq[SqW-1:0];
    s4_temp_next = s3_cold ? s3_temp - $signed({{(TempW-T2W){1'b0}}, s3_t2}) : s3_temp;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_d1 <= s3_d1;
      s4_flags <= s3_flags;
      s4_temp <= s4_temp_next;
      s4_cold <= s3_cold;
      s4_vcold <= s3_vcold;
      s4_dltsq <= s4_dltsq_next;
      s4_dl2sq <= s4_dl2sq_next;
      s4_off <= s3_off;
      s4_sens <= s3_sens;
    end
  end

  // stage 5: second-order offset and sensitivity
  logic [RawW-1:0]          s5_d1;
  fault_t                   s5_flags;
  logic signed [TempW-1:0]  s5_temp;
  logic signed [OffW-1:0]   s5_off, s5_off_next;
  logic signed [OffW-1:0]   s5_sens, s5_sens_next;
  logic [OffW-1:0]          off2_x3, off2, sens2_x7, dl2_x3, sens2;

  always_comb begin
    off2_x3 = OffW'({s4_dltsq, 1'b0}) + OffW'(s4_dltsq);
    off2 = off2_x3 >> 3;
    sens2_x7 = OffW'({s4_dltsq, 3'b0}) - OffW'(s4_dltsq);
    dl2_x3 = OffW'({s4_dl2sq, 1'b0}) + OffW'(s4_dl2sq);
    sens2 = (sens2_x7 >> 3) + (s4_vcold ? dl2_x3 : '0);
    if (s4_cold) begin
      s5_off_next = s4_off - $signed(off2);
      s5_sens_next = s4_sens - $signed(sens2);
    end else begin
      s5_off_next = s4_off;
      s5_sens_next = s4_sens;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_d1 <= s4_d1;
      s5_flags <= s4_flags;
      s5_temp <= s4_temp;
      s5_off <= s5_off_next;
      s5_sens <= s5_sens_next;
    end
  end

  // stage 6: d1 * sens as two partial products
  fault_t                   s6_flags;
  logic signed [TempW-1:0]  s6_temp;
  logic signed [OffW-1:0]   s6_off;
  logic [PpLoW-1:0]         s6_pplo, s6_pplo_next;
  logic signed [PpHiW-1:0]  s6_pphi, s6_pphi_next;

  always_comb begin
    s6_pplo_next = s5_d1 * s5_sens[SplitW-1:0];
    s6_pphi_next = $signed({1'b0, s5_d1}) * $signed(s5_sens[OffW-1:SplitW]);
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_flags <= s5_flags;
      s6_temp <= s5_temp;
      s6_off <= s5_off;
      s6_pplo <= s6_pplo_next;
      s6_pphi <= s6_pphi_next;
    end
  end

  // stage 7: sum of partial products
  fault_t                   s7_flags;
  logic signed [TempW-1:0]  s7_temp;
  logic signed [OffW-1:0]   s7_off;
  logic signed [FullW-1:0]  s7_prod, s7_prod_next;

  always_comb begin
    s7_prod_next = (FullW'(s6_pphi) <<< SplitW) + FullW'($signed({1'b0, s6_pplo}));
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_flags <= s6_flags;
      s7_temp <= s6_temp;
      s7_off <= s6_off;
      s7_prod <= s7_prod_next;
    end
  end

  // stage 8: scale and remove offset
  fault_t                   s8_flags;
  logic signed [TempW-1:0]  s8_temp;
  logic signed [DiffW-1:0]  s8_diff, s8_diff_next;
  logic signed [FullW-1:0]  p1_bias, p1_quot;

  always_comb begin
    p1_bias = s7_prod + (s7_prod[FullW-1] ? BiasP1 : '0);
    p1_quot = p1_bias >>> ShP1;
    s8_diff_next = DiffW'(p1_quot) - DiffW'(s7_off);
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_flags <= s7_flags;
      s8_temp <= s7_temp;
      s8_diff <= s8_diff_next;
    end
  end

  // stage 9: final scale, status priority, error zeroing
  status_t                  status_next;
  logic signed [DiffW-1:0]  p2_bias, p2_quot;

  always_comb begin
    p2_bias = s8_diff + (s8_diff[DiffW-1] ? BiasP2 : '0);
    p2_quot = p2_bias >>> ShP2;
    if (s8_flags.zero_coef) begin
      status_next = ST_ZERO_COEF;
    end else if (crc_stored != crc_result) begin
      status_next = ST_CRC_BAD;
    end else if (s8_flags.d1_zero) begin
      status_next = ST_D1_ZERO;
    end else if (s8_flags.d2_zero) begin
      status_next = ST_D2_ZERO;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      status <= status_next;
      if (status_next == ST_OK) begin
        pressure <= p2_quot[PresW-1:0];
        temperature_centi <= s8_temp;
      end else begin
        pressure <= '0;
        temperature_centi <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (pressure == '0) && (temperature_centi == '0))
    else $error("error result carries nonzero data");

  a_crc_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> (crc_stored == crc_computed))
    else $error("ok status with crc mismatch");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[1])
    else $error("transfer in did not reach stage 1");
`endif

endmodule
